// ===== rtl/rv32i_execute_unit_assert.svh =====
// Assertion macros for the execute unit.
`ifndef RV32I_EXECUTE_UNIT_ASSERT_SVH
`define RV32I_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RVX_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define RVX_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RVX_ASSERT(label, cond)
`define RVX_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/rvx_pkg.sv =====
package rvx_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FAULT   = 2'd3
  } status_t;

  // Major opcodes.
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0]  F7_ALT      = 7'h20;
  localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
  localparam logic [31:0] CODE_SIZE_RESET = 32'd4096;

endpackage

// ===== rtl/rvx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rv32i_execute_unit.sv =====
// RV32I execute unit.
// Input channel: in_valid/in_stall carry one instruction word in in_instr.
// Result channel: out_valid/out_stall carry status, next_pc and the
// destination write (index, value, flag) for each instruction, in order.
// Configuration: cfg_we writes cfg_code_size; the user must write it only
// while the unit is idle, which the unit does not enforce. Words pass stage 1,
// stage 2 (memory read), then execute into the output register. Throughput is
// one word per cycle while the receiver does not stall, set by the single
// execute stage, which forwards its register and memory writes to the next word.
// The register file sits in two 32-bit RAM copies and the data memory in four
// byte-lane RAMs, all with registered reads.
// After reset the unit runs a clearing pass over the register file and the
// data memory, one entry a cycle, taking no word meanwhile. The program
// counter resets to zero, code_size to 4096.
// When the receiver stalls, the output register holds and the unit stops
// taking words once its pipeline is full; nothing is lost.
module rv32i_execute_unit
  import rvx_pkg::*;
#(
  parameter int DMEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_next_pc,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic        out_dest_write,
  input  logic        cfg_we,
  input  logic [31:0] cfg_code_size
);

`include "rv32i_execute_unit_assert.svh"

  localparam int WORDS = (DMEM_BYTES + 3) / 4;
  localparam int CLR_N = (WORDS > 32) ? WORDS : 32;
  localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CA    = $clog2(CLR_N + 1);

  // Clearing pass after reset.
  logic          clr_r;
  logic [CA-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CA'(CLR_N - 1)) clr_r <= 1'b0;
    end
  end

  logic [31:0] code_size_r;
  always_ff @(posedge clk) begin
    if (!rst_n) code_size_r <= CODE_SIZE_RESET;
    else if (cfg_we) code_size_r <= cfg_code_size;
  end

  // Stages: 1 (register read), 2 (memory read), execute into output register.
  logic        s1_v_r;
  logic [31:0] s1_ins_r;
  logic        stall_ex;
  logic        adv;
  logic        s1_en;
  assign stall_ex = out_valid && out_stall;
  assign adv      = !stall_ex;
  assign s1_en    = adv || !s1_v_r;
  assign in_stall = clr_r || (s1_v_r && stall_ex);
  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // Which word feeds the RAM read address: the held one if stalled.
  logic [31:0] rd_ins;
  assign rd_ins = (s1_v_r && stall_ex) ? s1_ins_r : in_instr;

  // Stage 1 also fills while the stages ahead are held, if it is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_en) s1_v_r <= in_acc;
  end
  always_ff @(posedge clk) begin
    if (in_acc) s1_ins_r <= in_instr;
  end

  // Register file reads: launched from the word entering stage 1, or the held one.
  logic [31:0] rf_a, rf_b;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .re(1'b1), .raddr(rd_ins[19:15]), .rdata(rf_a));
  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .re(1'b1), .raddr(rd_ins[24:20]), .rdata(rf_b));

  // Bypass: a write in the same cycle as the read is not seen by the RAM.
  logic        byp_a_r, byp_b_r;
  logic [31:0] byp_d_r;
  always_ff @(posedge clk) begin
    byp_a_r <= rf_we && (rf_wa == rd_ins[19:15]);
    byp_b_r <= rf_we && (rf_wa == rd_ins[24:20]);
    byp_d_r <= rf_wd;
  end
  logic [31:0] a, b;

  // Memory-side stage: word in stage 1 computes address, reads byte lanes.
  logic [31:0] iimm1, simm1, maddr1;
  assign iimm1 = {{20{s1_ins_r[31]}}, s1_ins_r[31:20]};
  assign simm1 = {{20{s1_ins_r[31]}}, s1_ins_r[31:25], s1_ins_r[11:7]};
  assign maddr1 = a + ((s1_ins_r[6:0] == OP_STORE) ? simm1 : iimm1);

  // Stage 2 (memory read) registers.
  logic        s2_v_r;
  logic [31:0] s2_ins_r, s2_a_r, s2_b_r, s2_addr_r;
  logic [7:0]  lane_q [4];
  logic [WA-1:0] lane_ra [4];
  logic [WA-1:0] lane_wa [4];
  logic [7:0]    lane_wd [4];
  logic          lane_we [4];
  logic [7:0]  fwd_d_r [4];
  logic        fwd_v_r [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    // Lane k reads the access byte j = (k-addr)%4, at word (addr+j)/4.
    logic [33:0]  ak;
    always_comb begin
      ak = {2'b00, maddr1} + 34'((4 - int'(maddr1[1:0]) + k) % 4);
      lane_ra[k] = WA'(ak[33:2]);
    end
    rvx_ram #(.WIDTH(8), .DEPTH(WORDS)) u_lane (
      .clk, .we(lane_we[k]), .waddr(lane_wa[k]), .wdata(lane_wd[k]),
      .re(adv), .raddr(lane_ra[k]), .rdata(lane_q[k]));
    always_ff @(posedge clk) begin
      if (adv) begin
        fwd_v_r[k] <= lane_we[k] && (lane_wa[k] == lane_ra[k]);
        fwd_d_r[k] <= lane_wd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ins_r <= s1_ins_r;
      s2_a_r <= a;
      s2_b_r <= b;
      s2_addr_r <= maddr1;
    end
  end

  // Note: rs forwarding from stage 2 result into stage 1 operands.
  logic        ex_wr;
  logic [4:0]  ex_rd;
  logic [31:0] ex_val;

  // Execute stage.
  logic [31:0] pc_r;
  logic [31:0] ins, xa, xb;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] iimm, simm, bimm, jimm, uimm, lim, npc, val, tgt, aluo, opb;
  logic [31:0] ldw;
  logic [7:0]  mb [4];
  status_t     st;
  logic        wr, take, alt, st_en;
  logic [32:0] endaddr;
  logic [2:0]  size;

  assign ins = s2_ins_r;
  assign xa = s2_a_r;
  assign xb = s2_b_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mb[k] = fwd_v_r[k] ? fwd_d_r[k] : (clr_r ? 8'd0 : lane_q[k]);
    end
  end

  always_comb begin
    op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25];
    iimm = {{20{ins[31]}}, ins[31:20]};
    simm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    bimm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    jimm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    uimm = {ins[31:12], 12'd0};
    lim = code_size_r - 32'd4;
    npc = pc_r + 32'd4;
    st = ST_OK; wr = 1'b0; val = '0; take = 1'b0; tgt = '0; st_en = 1'b0;
    size = 3'd1;
    unique case (f3[1:0])
      2'd0: size = 3'd1;
      2'd1: size = 3'd2;
      default: size = 3'd4;
    endcase
    endaddr = {1'b0, s2_addr_r} + 33'(size);
    // Lanes are rotated so that byte 0 of the access comes first.
    ldw = 32'({mb[3], mb[2], mb[1], mb[0], mb[3], mb[2], mb[1], mb[0]} >>
              {s2_addr_r[1:0], 3'b000});
    alt = 1'b0; opb = xb; aluo = '0;
    if (op == OP_IMM) begin
      opb = iimm; alt = (f3 == 3'd5) && (f7 == F7_ALT);
    end else begin
      alt = (f7 == F7_ALT);
    end
    case (f3)
      3'd0: aluo = alt ? xa - opb : xa + opb;
      3'd1: aluo = xa << opb[4:0];
      3'd2: aluo = {31'd0, $signed(xa) < $signed(opb)};
      3'd3: aluo = {31'd0, xa < opb};
      3'd4: aluo = xa ^ opb;
      3'd5: aluo = alt ? 32'($signed(xa) >>> opb[4:0]) : xa >> opb[4:0];
      3'd6: aluo = xa | opb;
      default: aluo = xa & opb;
    endcase
    unique case (op)
      OP_LUI: begin
        wr = 1'b1; val = uimm;
      end
      OP_AUIPC: begin
        val = pc_r + uimm;
        if (val > lim) st = ST_RANGE; else wr = 1'b1;
      end
      OP_JAL: begin
        tgt = pc_r + jimm;
        if (tgt > lim) st = ST_RANGE;
        else begin wr = 1'b1; val = pc_r + 32'd4; npc = tgt; end
      end
      OP_JALR: begin
        tgt = (xa + iimm) & ~32'd1;
        if (f3 != 3'd0) st = ST_INVALID;
        else if (tgt > lim) st = ST_RANGE;
        else begin wr = 1'b1; val = pc_r + 32'd4; npc = tgt; end
      end
      OP_BRANCH: begin
        tgt = pc_r + bimm;
        if (tgt > lim) st = ST_RANGE;
        else begin
          case (f3)
            3'd0: take = xa == xb;
            3'd1: take = xa != xb;
            3'd4: take = $signed(xa) < $signed(xb);
            3'd5: take = !($signed(xa) < $signed(xb));
            3'd6: take = xa < xb;
            3'd7: take = xa >= xb;
            default: st = ST_INVALID;
          endcase
          if (take) npc = tgt;
        end
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) st = ST_INVALID;
        else if (endaddr > 33'(DMEM_BYTES)) st = ST_FAULT;
        else begin
          wr = 1'b1;
          case (f3)
            3'd0: val = {{24{ldw[7]}}, ldw[7:0]};
            3'd1: val = {{16{ldw[15]}}, ldw[15:0]};
            3'd4: val = {24'd0, ldw[7:0]};
            3'd5: val = {16'd0, ldw[15:0]};
            default: val = ldw;
          endcase
        end
      end
      OP_STORE: begin
        if (f3 > 3'd2) st = ST_INVALID;
        else if (endaddr > 33'(DMEM_BYTES)) st = ST_FAULT;
        else st_en = 1'b1;
      end
      OP_IMM: begin
        if (f3 == 3'd1 && f7 != 7'd0) st = ST_INVALID;
        else if (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT) st = ST_INVALID;
        else begin wr = 1'b1; val = aluo; end
      end
      OP_REG: begin
        if (f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
          wr = 1'b1; val = aluo;
        end else st = ST_INVALID;
      end
      OP_SYSTEM: begin
        if (ins != INSN_ECALL && ins != INSN_EBREAK) st = ST_INVALID;
      end
      default: st = ST_INVALID;
    endcase
    if (st != ST_OK) begin npc = pc_r; wr = 1'b0; end
    if (ins[11:7] == 5'd0) wr = 1'b0;
    if (!wr) val = '0;
  end

  logic fire;
  assign fire = s2_v_r && adv;
  assign ex_wr = fire && wr;
  assign ex_rd = ins[11:7];
  assign ex_val = val;

  // Stage 1 operands: the word executing ahead has not yet written the
  // register file, so its result is taken straight from the execute stage.
  logic fwd_a, fwd_b;
  assign fwd_a = s2_v_r && wr && (ex_rd == s1_ins_r[19:15]);
  assign fwd_b = s2_v_r && wr && (ex_rd == s1_ins_r[24:20]);
  assign a = (s1_ins_r[19:15] == 5'd0) ? 32'd0 :
             (fwd_a ? ex_val : (byp_a_r ? byp_d_r : rf_a));
  assign b = (s1_ins_r[24:20] == 5'd0) ? 32'd0 :
             (fwd_b ? ex_val : (byp_b_r ? byp_d_r : rf_b));

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= '0;
    else if (fire) pc_r <= npc;
  end

  // Register file writes: clear pass, else retiring result.
  assign rf_we = clr_r || ex_wr;
  assign rf_wa = clr_r ? clr_cnt_r[4:0] : ex_rd;
  assign rf_wd = clr_r ? 32'd0 : ex_val;

  // Byte-lane writes: clear pass, else stores.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_we[k] = clr_r;
      lane_wa[k] = WA'(clr_cnt_r);
      lane_wd[k] = 8'd0;
    end
    if (!clr_r && fire && st_en) begin
      for (int j = 0; j < 4; j++) begin
        if (3'(j) < size) begin
          lane_we[2'(s2_addr_r[1:0] + 2'(j))] = 1'b1;
          lane_wa[2'(s2_addr_r[1:0] + 2'(j))] =
            WA'(({1'b0, s2_addr_r} + 33'(j)) >> 2);
          lane_wd[2'(s2_addr_r[1:0] + 2'(j))] = xb[8*j +: 8];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= st;
      out_next_pc <= npc;
      out_dest_index <= wr ? ins[11:7] : 5'd0;
      out_dest_value <= val;
      out_dest_write <= wr;
    end
  end

  `RVX_ASSERT(a_no_take_in_clear, !(clr_r && in_acc))
  `RVX_ASSERT(a_bad_status_no_write, !(out_valid && out_status != ST_OK && out_dest_write))
  `RVX_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, out_valid)

endmodule

// ===== dv/tb_top.sv =====
module tb_top
  import rvx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DMEM = 4096;
  localparam int LIMIT_CYCLES = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_next_pc;
  logic [4:0]  out_dest_index;
  logic [31:0] out_dest_value;
  logic        out_dest_write;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_code_size = '0;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_write;
  } retire_t;

  // Words waiting to be offered, and the retirements the predictor expects.
  logic [31:0] pending_words[$];
  retire_t     expected_retires[$];

  // Predictor's own architectural state.
  logic [31:0] arch_regs[32];
  logic [31:0] arch_pc;
  logic [7:0]  arch_mem[DMEM];
  logic [31:0] arch_code_size;

  int  errors = 0;
  int  cycles = 0;
  bit  hold_off = 1'b0;

  rv32i_execute_unit #(.DMEM_BYTES(DMEM)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_instr(in_instr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_next_pc(out_next_pc),
    .out_dest_index(out_dest_index), .out_dest_value(out_dest_value),
    .out_dest_write(out_dest_write),
    .cfg_we(cfg_we), .cfg_code_size(cfg_code_size)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic bit target_ok(logic [31:0] t);
    logic [31:0] top;
    top = arch_code_size - 32'd4;
    return t <= top;
  endfunction

  function automatic logic [31:0] alu_op(logic [2:0] f3, bit alt, logic [31:0] a,
                                         logic [31:0] b);
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << b[4:0];
      3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      3'd3: return (a < b) ? 32'd1 : 32'd0;
      3'd4: return a ^ b;
      3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  // Executes one word against the predictor's state and queues its retirement.
  task automatic execute_word(logic [31:0] w);
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, iimm, simm, bimm, jimm, pc, npc, val, addr, t;
    logic [1:0]  st;
    bit          wr, take;
    int          size;
    retire_t     r;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = arch_regs[w[19:15]]; b = arch_regs[w[24:20]];
    iimm = sx({20'd0, w[31:20]}, 12);
    simm = sx({20'd0, w[31:25], w[11:7]}, 12);
    bimm = sx({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
    jimm = sx({11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
    pc = arch_pc; npc = pc + 32'd4; st = ST_OK; wr = 1'b0; val = '0;
    take = 1'b0;
    case (op)
      OP_LUI: begin
        wr = 1'b1; val = {w[31:12], 12'd0};
      end
      OP_AUIPC: begin
        val = pc + {w[31:12], 12'd0};
        if (!target_ok(val)) st = ST_RANGE; else wr = 1'b1;
      end
      OP_JAL: begin
        if (!target_ok(pc + jimm)) st = ST_RANGE;
        else begin
          wr = 1'b1; val = pc + 32'd4; npc = pc + jimm;
        end
      end
      OP_JALR: begin
        t = (a + iimm) & ~32'd1;
        if (f3 != 3'd0) st = ST_INVALID;
        else if (!target_ok(t)) st = ST_RANGE;
        else begin
          wr = 1'b1; val = pc + 32'd4; npc = t;
        end
      end
      OP_BRANCH: begin
        if (!target_ok(pc + bimm)) st = ST_RANGE;
        else begin
          case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: st = ST_INVALID;
          endcase
          if (take) npc = pc + bimm;
        end
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) st = ST_INVALID;
        else begin
          size = 1 << f3[1:0];
          addr = a + iimm;
          if (64'(addr) + size > DMEM) st = ST_FAULT;
          else begin
            for (int k = 0; k < size; k++) val[8*k +: 8] = arch_mem[addr + k];
            if (f3 == 3'd0) val = sx(val, 8);
            else if (f3 == 3'd1) val = sx(val, 16);
            wr = 1'b1;
          end
        end
      end
      OP_STORE: begin
        if (f3 > 3'd2) st = ST_INVALID;
        else begin
          size = 1 << f3;
          addr = a + simm;
          if (64'(addr) + size > DMEM) st = ST_FAULT;
          else for (int k = 0; k < size; k++) arch_mem[addr + k] = b[8*k +: 8];
        end
      end
      OP_IMM: begin
        if (f3 == 3'd1 && f7 != 7'd0) st = ST_INVALID;
        else if (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT) st = ST_INVALID;
        else begin
          wr = 1'b1; val = alu_op(f3, f3 == 3'd5 && f7 == F7_ALT, a, iimm);
        end
      end
      OP_REG: begin
        if (f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
          wr = 1'b1; val = alu_op(f3, f7 == F7_ALT, a, b);
        end else st = ST_INVALID;
      end
      OP_SYSTEM: begin
        if (w != INSN_ECALL && w != INSN_EBREAK) st = ST_INVALID;
      end
      default: st = ST_INVALID;
    endcase
    if (st != ST_OK) begin
      npc = pc; wr = 1'b0;
    end
    if (rd == 5'd0) wr = 1'b0;
    if (wr) arch_regs[rd] = val;
    arch_pc = npc;
    r.status = st; r.next_pc = npc;
    r.dest_index = wr ? rd : 5'd0;
    r.dest_value = wr ? val : 32'd0;
    r.dest_write = wr;
    expected_retires.push_back(r);
  endtask

  // Random word builder; small immediates, used three times in four, keep most addresses inside the store.
  function automatic logic [31:0] rand_word();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    int          pick;
    rd = 5'($urandom); rs1 = 5'($urandom_range(0, 7)); rs2 = 5'($urandom);
    f3 = 3'($urandom);
    imm = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 8) return {20'($urandom), rd, OP_LUI};
    if (pick < 12) return {20'($urandom_range(0, 1)), rd, OP_AUIPC};
    if (pick < 30) return {imm, rs1, f3, rd, OP_IMM};
    if (pick < 48) begin
      if ($urandom_range(0, 1)) return {F7_ALT, rs2, rs1, f3, rd, OP_REG};
      return {7'd0, rs2, rs1, f3, rd, OP_REG};
    end
    if (pick < 60) return {imm, 5'd0, f3, rd, OP_LOAD};
    if (pick < 72) return {imm[11:5], rs2, 5'd0, f3, imm[4:0], OP_STORE};
    if (pick < 80) return {7'($urandom_range(0, 3) == 0 ? 7'h7f : 7'd0), rs2, rs1, f3,
                           5'($urandom_range(0, 31)), OP_BRANCH};
    if (pick < 84) return {1'b0, 10'($urandom_range(0, 255)), 1'b0, 8'd0, rd, OP_JAL};
    if (pick < 88) return {12'($urandom_range(0, 1023)), 5'd0, 3'($urandom_range(0, 1) ?
                           0 : f3), rd, OP_JALR};
    if (pick < 91) return $urandom_range(0, 1) ? INSN_ECALL : INSN_EBREAK;
    if (pick < 94) return {imm, rs1, f3, rd, OP_IMM} | 32'h8000_0000;
    return $urandom;
  endfunction

  // Sender: bursts of words with random gaps, payload held while stalled.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_instr <= pending_words[0];
          execute_word(pending_words.pop_front());
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall pattern, a long hold-off when asked.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Monitor: compare each accepted retirement with the oldest expectation.
  always @(posedge clk) begin
    retire_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_retires.size() == 0) begin
        $display("%0t: unexpected word status=%0d pc=%h", $time, out_status, out_next_pc);
        errors <= errors + 1;
      end else begin
        e = expected_retires.pop_front();
        if (out_status !== e.status || out_next_pc !== e.next_pc ||
            out_dest_index !== e.dest_index || out_dest_value !== e.dest_value ||
            out_dest_write !== e.dest_write) begin
          $display("%0t: mismatch expected st=%0d pc=%h rd=%0d v=%h w=%0d",
                   $time, e.status, e.next_pc, e.dest_index, e.dest_value, e.dest_write);
          $display("%0t:          actual st=%0d pc=%h rd=%0d v=%h w=%0d",
                   $time, out_status, out_next_pc, out_dest_index, out_dest_value,
                   out_dest_write);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || expected_retires.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_code_size(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_code_size <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    arch_code_size = v;
  endtask

  initial begin
    logic [31:0] sizes[4];
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    for (int i = 0; i < DMEM; i++) arch_mem[i] = '0;
    arch_pc = '0;
    arch_code_size = CODE_SIZE_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: field extremes, every class and the special cases.
    pending_words.push_back({20'hfffff, 5'd1, OP_LUI});
    pending_words.push_back({12'hfff, 5'd0, 3'd0, 5'd2, OP_IMM});
    pending_words.push_back({12'h7ff, 5'd2, 3'd0, 5'd0, OP_IMM});
    pending_words.push_back({7'd0, 5'd31, 5'd1, 3'd1, 5'd3, OP_IMM});
    pending_words.push_back({F7_ALT, 5'd4, 5'd1, 3'd5, 5'd4, OP_IMM});
    pending_words.push_back({7'd1, 5'd4, 5'd1, 3'd1, 5'd4, OP_IMM});
    pending_words.push_back({F7_ALT, 5'd2, 5'd1, 3'd5, 5'd5, OP_REG});
    pending_words.push_back({F7_ALT, 5'd2, 5'd1, 3'd4, 5'd5, OP_REG});
    pending_words.push_back({7'd0, 5'd2, 5'd1, 3'd0, 5'd0, OP_STORE});
    pending_words.push_back({12'h002, 5'd0, 3'd1, 5'd6, OP_LOAD});
    pending_words.push_back({12'h001, 5'd0, 3'd4, 5'd7, OP_LOAD});
    pending_words.push_back({12'h000, 5'd0, 3'd5, 5'd8, OP_LOAD});
    pending_words.push_back({12'hffe, 5'd0, 3'd2, 5'd9, OP_LOAD});
    pending_words.push_back({12'h000, 5'd0, 3'd3, 5'd9, OP_LOAD});
    pending_words.push_back({7'd0, 5'd1, 5'd0, 3'd6, 5'd8, OP_BRANCH});
    pending_words.push_back({7'h7f, 5'd1, 5'd0, 3'd0, 5'd0, OP_BRANCH});
    pending_words.push_back({7'd0, 5'd1, 5'd0, 3'd2, 5'd8, OP_BRANCH});
    pending_words.push_back({1'b0, 10'd4, 1'b0, 8'd0, 5'd10, OP_JAL});
    pending_words.push_back({12'h011, 5'd0, 3'd0, 5'd11, OP_JALR});
    pending_words.push_back({12'h000, 5'd0, 3'd1, 5'd11, OP_JALR});
    pending_words.push_back({20'hfffff, 5'd12, OP_AUIPC});
    pending_words.push_back(INSN_ECALL);
    pending_words.push_back(INSN_EBREAK);
    pending_words.push_back(32'h0000_100f);
    pending_words.push_back(32'hffff_ffff);
    drain();

    // Random phases over several code sizes, extremes included.
    sizes[0] = 32'd4; sizes[1] = 32'hffff_ffff; sizes[2] = 32'd1; sizes[3] = 32'd512;
    for (int ph = 0; ph < 4; ph++) begin
      write_code_size(sizes[ph]);
      for (int i = 0; i < 400; i++) pending_words.push_back(rand_word());
      if (ph == 1) begin
        // Long receiver hold-off so that the pipeline fills and backs up.
        repeat (20) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
